FILE: rtl/core/wdo_pkg.sv
// Shared constants, types and state encodings of the window disturbance observer.
package wdo_pkg;

   // Field widths and fixed-point format
   localparam int FIELD_W    = 32;
   localparam int FRAC_W     = 16;
   localparam int WINDOW_DEF = 10;

   // Stream word layout
   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 2;

   // Bit positions of the result flags in rsp_tuser
   localparam int USER_VALID     = 0;
   localparam int USER_SPAN_ZERO = 1;

   // Saturation limits of the Q16.16 result
   localparam logic [FIELD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [FIELD_W-1:0] SAT_MIN = 32'h8000_0000;

   // Top level sequencer
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } state_type;

   // Divider sequencer
   typedef enum logic [2:0] {
      DIV_IDLE,
      DIV_ABS,
      DIV_CHECK,
      DIV_ITER,
      DIV_SAT
   } div_state_type;

   // Window status seen by the sequencer
   typedef struct packed {
      logic full;
      logic span_zero;
   } win_status_type;

endpackage

FILE: rtl/core/wdo_window.sv
// Sample window shift line with running acceleration sum and last time step.
module wdo_window #(
   parameter int WINDOW = wdo_pkg::WINDOW_DEF,
   parameter int SUM_W  = wdo_pkg::FIELD_W + $clog2(WINDOW)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               shift_en,
   input  logic [wdo_pkg::FIELD_W-1:0]        sample_time,
   input  logic signed [wdo_pkg::FIELD_W-1:0] velocity,
   input  logic signed [wdo_pkg::FIELD_W-1:0] commanded_accel,
   output wdo_pkg::win_status_type            status,
   output logic [wdo_pkg::FIELD_W-1:0]        span,
   output logic signed [wdo_pkg::FIELD_W:0]   vel_delta,
   output logic signed [SUM_W-1:0]            accel_sum,
   output logic [wdo_pkg::FIELD_W-1:0]        time_step
);
   import wdo_pkg::*;

   localparam int FILL_W = $clog2(WINDOW + 1);

   // Taps, oldest at index 0; all zero after reset stands for the seed sample
   logic [FIELD_W-1:0] time_ff  [WINDOW];
   logic [FIELD_W-1:0] vel_ff   [WINDOW];
   logic [FIELD_W-1:0] accel_ff [WINDOW];

   logic [FILL_W-1:0]       fill_ff, fill_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [FIELD_W-1:0]      step_ff, step_in;
   logic signed [SUM_W-1:0] old_accel_ext, new_accel_ext;

   // Next values: the oldest word leaves the sum as the new one enters
   always_comb begin
      old_accel_ext = SUM_W'(signed'(accel_ff[0]));
      new_accel_ext = SUM_W'(commanded_accel);
      sum_in        = sum_ff - old_accel_ext + new_accel_ext;
      step_in       = sample_time - time_ff[WINDOW-1];
      fill_in       = (fill_ff == FILL_W'(WINDOW)) ? fill_ff : fill_ff + 1'b1;
   end

   // Shift line and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            time_ff[i]  <= '0;
            vel_ff[i]   <= '0;
            accel_ff[i] <= '0;
         end
         fill_ff <= FILL_W'(1);
         sum_ff  <= '0;
         step_ff <= '0;
      end else if (shift_en) begin
         for (int i = 0; i < WINDOW - 1; i++) begin
            time_ff[i]  <= time_ff[i+1];
            vel_ff[i]   <= vel_ff[i+1];
            accel_ff[i] <= accel_ff[i+1];
         end
         time_ff[WINDOW-1]  <= sample_time;
         vel_ff[WINDOW-1]   <= velocity;
         accel_ff[WINDOW-1] <= commanded_accel;
         fill_ff            <= fill_in;
         sum_ff             <= sum_in;
         step_ff            <= step_in;
      end
   end

   // Window figures for the estimate
   assign span             = time_ff[WINDOW-1] - time_ff[0];
   assign vel_delta        = signed'({vel_ff[WINDOW-1][FIELD_W-1], vel_ff[WINDOW-1]})
                           - signed'({vel_ff[0][FIELD_W-1], vel_ff[0]});
   assign accel_sum        = sum_ff;
   assign time_step        = step_ff;
   assign status.full      = (fill_ff == FILL_W'(WINDOW));
   assign status.span_zero = (span == '0);

endmodule

FILE: rtl/core/wdo_mul.sv
// Bit-serial signed multiplier forming the Q32.32 numerator, one step bit per cycle.
module wdo_mul #(
   parameter int SUM_W = wdo_pkg::FIELD_W + $clog2(wdo_pkg::WINDOW_DEF),
   parameter int NUM_W = SUM_W + wdo_pkg::FIELD_W + 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [SUM_W-1:0]            accel_sum,
   input  logic [wdo_pkg::FIELD_W-1:0]        time_step,
   input  logic signed [wdo_pkg::FIELD_W:0]   vel_delta,
   output logic                               done,
   output logic signed [NUM_W-1:0]            numer
);
   import wdo_pkg::*;

   localparam int CNT_W = $clog2(FIELD_W + 1);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [FIELD_W-1:0]      mplier_ff, mplier_in;
   logic signed [NUM_W-1:0] acc_ff, acc_in;
   logic signed [NUM_W-1:0] sum_ext, dv_ext;

   // MSB-first shift and add, then a final step takes off the velocity change
   always_comb begin
      sum_ext   = NUM_W'(accel_sum);
      dv_ext    = NUM_W'(vel_delta) <<< FRAC_W;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         mplier_in = time_step;
         acc_in    = '0;
      end else if (busy_ff) begin
         if (cnt_ff == CNT_W'(FIELD_W)) begin
            acc_in  = acc_ff - dv_ext;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            acc_in    = (acc_ff <<< 1) + (mplier_ff[FIELD_W-1] ? sum_ext : '0);
            mplier_in = mplier_ff << 1;
            cnt_in    = cnt_ff + 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign done  = done_ff;
   assign numer = acc_ff;

endmodule

FILE: rtl/core/wdo_div.sv
// Restoring divider by the window span, one quotient bit per cycle, with saturation.
module wdo_div #(
   parameter int NUM_W = wdo_pkg::FIELD_W + $clog2(wdo_pkg::WINDOW_DEF) + wdo_pkg::FIELD_W + 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [NUM_W-1:0]     numer,
   input  logic [wdo_pkg::FIELD_W-1:0] span,
   output logic                        done,
   output logic [wdo_pkg::FIELD_W-1:0] quotient
);
   import wdo_pkg::*;

   localparam int HI_W  = NUM_W - FIELD_W;
   localparam int CNT_W = $clog2(FIELD_W);

   div_state_type      state_ff, state_in;
   logic               done_ff, done_in;
   logic               neg_ff, neg_in;
   logic               ovf_ff, ovf_in;
   logic [NUM_W-1:0]   mag_ff, mag_in;
   logic [FIELD_W-1:0] rem_ff, rem_in;
   logic [FIELD_W-1:0] low_ff, low_in;
   logic [FIELD_W-1:0] quo_ff, quo_in;
   logic [FIELD_W-1:0] res_ff, res_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [FIELD_W:0]   trial;
   logic               qbit;

   // Sequencer and datapath next values
   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      mag_in   = mag_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      quo_in   = quo_ff;
      res_in   = res_ff;
      cnt_in   = cnt_ff;
      trial    = {rem_ff, low_ff[FIELD_W-1]};
      qbit     = (trial >= {1'b0, span});
      case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               mag_in   = numer;
               state_in = DIV_ABS;
            end
         end
         DIV_ABS: begin
            neg_in   = mag_ff[NUM_W-1];
            mag_in   = mag_ff[NUM_W-1] ? -mag_ff : mag_ff;
            state_in = DIV_CHECK;
         end
         DIV_CHECK: begin
            // high part not below the span means a quotient of 2^32 or more
            ovf_in = (mag_ff[NUM_W-1:FIELD_W] >= HI_W'(span));
            rem_in = mag_ff[FIELD_W +: FIELD_W];
            low_in = mag_ff[FIELD_W-1:0];
            quo_in = '0;
            cnt_in = '0;
            state_in = ovf_in ? DIV_SAT : DIV_ITER;
         end
         DIV_ITER: begin
            rem_in = qbit ? FIELD_W'(trial - {1'b0, span}) : trial[FIELD_W-1:0];
            quo_in = {quo_ff[FIELD_W-2:0], qbit};
            low_in = low_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(FIELD_W - 1)) begin
               state_in = DIV_SAT;
            end
         end
         DIV_SAT: begin
            if (!neg_ff) begin
               res_in = (ovf_ff || quo_ff[FIELD_W-1]) ? SAT_MAX : quo_ff;
            end else if (ovf_ff || (quo_ff[FIELD_W-1] && (|quo_ff[FIELD_W-2:0]))) begin
               res_in = SAT_MIN;
            end else begin
               res_in = -quo_ff;
            end
            done_in  = 1'b1;
            state_in = DIV_IDLE;
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      ovf_ff <= ovf_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      res_ff <= res_in;
   end

   assign done     = done_ff;
   assign quotient = res_ff;

endmodule

FILE: rtl/core/window_disturbance_observer.sv
// Window disturbance observer top level: stream ports, sequencer and result register.
//
// Every sample word taken on req_ gives exactly one result word on rsp_. Until the window
// holds WINDOW samples (the reset seed counts as one) the result is zero with
// estimate_valid low; a zero time span gives zero with span_zero high. Otherwise the
// estimate is (sum of window accelerations * last time step - velocity change) / span in
// signed Q16.16, truncated toward zero and saturated to 32 bits. A sample is taken only
// while the block is idle. A full estimate passes through the bit-serial multiplier
// (shift and add over the time step bits, then an adjust step for the velocity change)
// and the bit-serial divider (sign, range check, quotient bits and saturation), each
// working one bit per cycle. The output register holds one finished word, so the next
// sample is taken while that word waits for rsp_tready.
module window_disturbance_observer #(
   parameter int WINDOW = wdo_pkg::WINDOW_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // sample_time [31:0], velocity [63:32], commanded_accel [95:64]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [wdo_pkg::REQ_DATA_W-1:0]   req_tdata,
   // disturbance [31:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [wdo_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // estimate_valid [0], span_zero [1]
   output logic [wdo_pkg::RSP_USER_W-1:0]   rsp_tuser
);
   import wdo_pkg::*;

   localparam int SUM_W = FIELD_W + $clog2(WINDOW);
   localparam int NUM_W = SUM_W + FIELD_W + 1;

   state_type               state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0]   rsp_user_ff, rsp_user_in;
   logic [RSP_DATA_W-1:0]   res_data_ff, res_data_in;
   logic [RSP_USER_W-1:0]   res_user_ff, res_user_in;

   logic                    shift_en;
   logic                    mul_start, mul_done;
   logic                    div_start, div_done;
   win_status_type          win_status;
   logic [FIELD_W-1:0]      span;
   logic signed [FIELD_W:0] vel_delta;
   logic signed [SUM_W-1:0] accel_sum;
   logic [FIELD_W-1:0]      time_step;
   logic signed [NUM_W-1:0] numer;
   logic [FIELD_W-1:0]      quotient;

   assign req_tready = (state_ff == ST_IDLE);
   assign shift_en   = req_tvalid && req_tready;

   wdo_window #(
      .WINDOW (WINDOW),
      .SUM_W  (SUM_W)
   ) u_window (
      .clock           (clock),
      .reset           (reset),
      .shift_en        (shift_en),
      .sample_time     (req_tdata[FIELD_W-1:0]),
      .velocity        (req_tdata[2*FIELD_W-1:FIELD_W]),
      .commanded_accel (req_tdata[3*FIELD_W-1:2*FIELD_W]),
      .status          (win_status),
      .span            (span),
      .vel_delta       (vel_delta),
      .accel_sum       (accel_sum),
      .time_step       (time_step)
   );

   wdo_mul #(
      .SUM_W (SUM_W),
      .NUM_W (NUM_W)
   ) u_mul (
      .clock     (clock),
      .reset     (reset),
      .start     (mul_start),
      .accel_sum (accel_sum),
      .time_step (time_step),
      .vel_delta (vel_delta),
      .done      (mul_done),
      .numer     (numer)
   );

   wdo_div #(
      .NUM_W (NUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (numer),
      .span     (span),
      .done     (div_done),
      .quotient (quotient)
   );

   // Sequencer and output register next values
   always_comb begin
      state_in     = state_ff;
      res_data_in  = res_data_ff;
      res_user_in  = res_user_ff;
      mul_start    = 1'b0;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      case (state_ff)
         ST_IDLE: begin
            if (shift_en) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            res_data_in = '0;
            res_user_in = '0;
            if (!win_status.full) begin
               state_in = ST_OUT;
            end else if (win_status.span_zero) begin
               res_user_in[USER_VALID]     = 1'b1;
               res_user_in[USER_SPAN_ZERO] = 1'b1;
               state_in                    = ST_OUT;
            end else begin
               mul_start = 1'b1;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_data_in             = quotient;
               res_user_in             = '0;
               res_user_in[USER_VALID] = 1'b1;
               state_in                = ST_OUT;
            end
         end
         ST_OUT: begin
            // hand over once the output register is free or being emptied
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_data_ff;
               rsp_user_in  = res_user_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload registers
   always_ff @(posedge clock) begin
      res_data_ff <= res_data_in;
      res_user_ff <= res_user_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // A result without an estimate carries zero and no span flag
   a_no_estimate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[USER_VALID] |-> (rsp_tdata == '0) && !rsp_tuser[USER_SPAN_ZERO])
      else $error("result without estimate is not zero");

   // A zero span forces a zero disturbance
   a_span_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[USER_SPAN_ZERO] |-> (rsp_tdata == '0))
      else $error("zero span result carries data");

   // Once a sample is taken the block stops taking more
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      shift_en |=> !req_tready)
      else $error("second sample taken while busy");

   // The multiplier only finishes while the sequencer waits for it
   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_MUL))
      else $error("multiplier finished outside its phase");

endmodule
